FILE: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and defaults shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VAL_W     = 32;

  // Request kinds.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                    kind;
    logic signed [VAL_W-1:0] value;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] popped;
  } spq_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       load;
    logic [1:0] status;
  } spq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
  } spq_sts_t;

  typedef enum logic {
    CS_IDLE,
    CS_RESULT
  } spq_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts requests, issues push/pop commands to the
// cell array and tracks whether the result register holds an untaken result.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_kind,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire spq_sts_t sts,
  output spq_cmd_t      cmd
);

  spq_state_t state_r;
  spq_state_t state_nxt;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.status = ST_OK;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    accept     = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
      end
      CS_RESULT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          state_nxt = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase

    accept = in_valid && in_ready;
    if (accept) begin
      state_nxt = CS_RESULT;
      cmd.load  = 1'b1;
      if (in_kind == KIND_PUSH) begin
        if (sts.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.push = 1'b1;
        end
      end else begin
        if (sts.empty) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.pop = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/spq_dpath.sv
// ----------------------------------------------------------------------------
// spq_dpath
// Shift-cell array kept in descending order (largest in cell 0), the entry
// count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_dpath
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic signed [VAL_W-1:0] in_value,
  input  wire spq_cmd_t                cmd,
  output spq_sts_t                     sts,
  output spq_out_t                     out_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [VAL_W-1:0] cell_r [DEPTH];
  logic [DEPTH-1:0]        gt;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  spq_out_t                out_r;

  // A cell keeps its place on push when it holds a value strictly larger
  // than the new one; the new value lands in the first cell that does not.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] cell_nxt;

    assign gt[i] = (CW'(i) < count_r) && (cell_r[i] > in_value);

    always_comb begin
      cell_nxt = cell_r[i];
      if (cmd.push && !gt[i]) begin
        if (i == 0) begin
          cell_nxt = in_value;
        end else if (gt[(i == 0) ? 0 : i-1]) begin
          cell_nxt = in_value;
        end else begin
          cell_nxt = cell_r[(i == 0) ? 0 : i-1];
        end
      end else if (cmd.pop && (i < DEPTH-1)) begin
        cell_nxt = cell_r[(i < DEPTH-1) ? i+1 : i];
      end
    end

    always_ff @(posedge clk) begin
      cell_r[i] <= cell_nxt;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.status <= cmd.status;
      out_r.popped <= cmd.pop ? cell_r[0] : '0;
    end
  end

  assign sts.full  = (count_r == CW'(DEPTH));
  assign sts.empty = (count_r == '0);
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue of signed 32-bit values with largest-first removal.
// ----------------------------------------------------------------------------
// Each request on the input channel is either a push of a value or a pop of
// the largest stored value, and each one yields exactly one result transfer
// carrying a status (ok, full or empty) and, for a successful pop, the value
// removed. Values are held in a shift-cell array sorted in descending order,
// so a push compares its value against every cell in parallel and the cells
// below the insertion point move down one place, while a pop moves every cell
// up one place and returns the head. Equal values leave in reverse arrival
// order: a new value goes ahead of stored values equal to it. A request
// is carried out and its result registered at the edge that accepts it, so one
// transfer per cycle is sustained as long as results are taken; the result
// register is the only buffer, and a new request is taken in the same cycle
// the waiting result is taken. A push to a full queue and a pop from an empty
// one change nothing and return a zero value.
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire spq_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output spq_out_t      out_data
);

  // Command and status between the controller and the cell array.
  spq_cmd_t cmd;
  spq_sts_t sts;

  // The controller owns both handshakes and decides, from the full and empty
  // flags, whether an accepted request touches the store.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the sorted cells, the entry count and the result.
  spq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (in_data.value),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

FILE: sim/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the largest-first sorted priority queue.
// ----------------------------------------------------------------------------
// A list of requests is built up front. It opens with a directed part that
// covers a pop on an empty queue, pushes of the most positive and most
// negative values and of equal values, a fill to capacity, and a push that is
// refused because the queue is full. A long random part follows, in which
// push-heavy and pop-heavy stretches take turns so that the queue keeps
// swinging between empty and full. A clocked driver hands the requests to the
// block. A local shadow copy of the sorted store predicts one result for
// every accepted request, and a clocked monitor compares each result transfer
// against the oldest prediction, one field at a time. Both sides pause at
// random between transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned QDEPTH      = DEPTH_DEF;
  localparam int          N_RANDOM    = 1500;
  localparam int          CYCLE_LIMIT = 200000;

  // Clock, reset and the block's ports. Every input of the block has a known
  // value from time zero.
  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  spq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  spq_out_t out_data;

  sorted_priority_queue #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Requests that have not yet been presented, and the results that the
  // shadow queue expects, oldest first.
  spq_in_t  pending_reqs[$];
  spq_out_t expected_results[$];

  // Shadow copy of the sorted store: ascending order, largest at the top.
  logic signed [VAL_W-1:0] shadow_vals[QDEPTH];
  int unsigned             shadow_count = 0;

  int errors        = 0;
  int n_accepted    = 0;
  int n_results     = 0;
  int n_pop_ok      = 0;
  int n_push_ok     = 0;
  int n_full_refuse = 0;
  int n_empty_pop   = 0;
  int n_cycles      = 0;

  // Works out the result of one request and updates the shadow store. A new
  // value lands in front of the first stored value that is strictly larger,
  // so it sits above any equal values already stored.
  function automatic spq_out_t apply_request(spq_in_t req);
    spq_out_t    res;
    int unsigned pos;
    int unsigned j;
    res.status = ST_OK;
    res.popped = '0;
    if (req.kind == KIND_PUSH) begin
      if (shadow_count >= QDEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && !($signed(shadow_vals[pos]) > $signed(req.value)))
          pos++;
        for (j = shadow_count; j > pos; j--)
          shadow_vals[j] = shadow_vals[j-1];
        shadow_vals[pos] = req.value;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        shadow_count--;
        res.popped = shadow_vals[shadow_count];
      end
    end
    return res;
  endfunction

  function automatic spq_in_t make_req(logic kind, logic signed [VAL_W-1:0] value);
    spq_in_t r;
    r.kind  = kind;
    r.value = value;
    return r;
  endfunction

  // Values for pushes: many small values so that ties are common, a few
  // extremes and values close to them, and the rest drawn over the full range.
  function automatic logic signed [VAL_W-1:0] draw_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1:    v = $signed($urandom_range(0, 6)) - 3;
      2: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = 32'sh0000_0000;
          3:       v = 32'shFFFF_FFFF;
          default: v = 32'sh0000_0001;
        endcase
      end
      3:       v = 32'sh7FFF_FFFF - $urandom_range(0, 3);
      4:       v = 32'sh8000_0000 + $urandom_range(0, 3);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Idle cycles before the next transfer on one side. Now and then a side
  // enters a calm stretch in which it never pauses.
  int drv_calm = 0;
  int mon_calm = 0;

  function automatic int draw_pause(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  // Driver. When a request is accepted, its result is predicted at that very
  // edge. The next request goes out after the drawn pause; a request that
  // has not yet been accepted is held with its payload unchanged. in_valid
  // gets at most one assignment per edge.
  int drv_wait = 0;

  always @(posedge clk) begin
    int       wait_n;
    logic     fire;
    spq_out_t pred;
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_wait <= 0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        pred = apply_request(in_data);
        expected_results.push_back(pred);
        if (pred.status == ST_OK) begin
          if (in_data.kind == KIND_PUSH) begin
            n_push_ok++;
          end else begin
            n_pop_ok++;
          end
        end
        n_accepted++;
        wait_n = draw_pause(drv_calm);
      end else begin
        wait_n = drv_wait;
      end
      if (in_valid && !in_ready) begin
        // Still waiting for the block to take the current request.
      end else if (wait_n > 0) begin
        in_valid <= 1'b0;
        drv_wait <= wait_n - 1;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_reqs.pop_front();
        drv_wait <= 0;
      end else begin
        in_valid <= 1'b0;
        drv_wait <= 0;
      end
    end
  end

  // Monitor. Checks every result transfer against the oldest prediction and
  // stalls out_ready for a drawn number of cycles after each transfer.
  int mon_wait = 0;

  always @(posedge clk) begin
    int       wait_n;
    spq_out_t exp_res;
    if (!rst_n) begin
      out_ready <= 1'b0;
      mon_wait  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: status %0d popped %0d",
                 out_data.status, $signed(out_data.popped));
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_data.status !== exp_res.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   exp_res.status, out_data.status);
            errors++;
          end
          if (out_data.popped !== exp_res.popped) begin
            $error("popped mismatch: expected %0d, actual %0d",
                   $signed(exp_res.popped), $signed(out_data.popped));
            errors++;
          end
          case (exp_res.status)
            ST_FULL:  n_full_refuse++;
            ST_EMPTY: n_empty_pop++;
            default:  ;
          endcase
        end
        wait_n = draw_pause(mon_calm);
      end else begin
        wait_n = mon_wait;
      end
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        mon_wait  <= wait_n - 1;
      end else begin
        out_ready <= 1'b1;
        mon_wait  <= 0;
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               n_cycles, expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int  seg_left;
    bit  push_heavy;
    int  push_pct;
    int  i;

    // Directed part. The store is empty, so a pop must report empty.
    pending_reqs.push_back(make_req(KIND_POP, 32'sh0000_0000));
    // Extremes, zero, minus one, and a run of equal values.
    pending_reqs.push_back(make_req(KIND_PUSH, 32'sh7FFF_FFFF));
    pending_reqs.push_back(make_req(KIND_PUSH, 32'sh8000_0000));
    pending_reqs.push_back(make_req(KIND_PUSH, 32'sh0000_0000));
    pending_reqs.push_back(make_req(KIND_PUSH, 32'shFFFF_FFFF));
    pending_reqs.push_back(make_req(KIND_PUSH, 32'sh0000_0005));
    pending_reqs.push_back(make_req(KIND_PUSH, 32'sh0000_0005));
    pending_reqs.push_back(make_req(KIND_PUSH, 32'sh7FFF_FFFF));
    pending_reqs.push_back(make_req(KIND_PUSH, 32'sh8000_0000));
    // Fill the rest of the store with random values.
    for (i = 8; i < QDEPTH; i++)
      pending_reqs.push_back(make_req(KIND_PUSH, $urandom));
    // The store is now full, so this push is refused; the pop flag carries a
    // nonzero value to show that the value is ignored on a pop.
    pending_reqs.push_back(make_req(KIND_PUSH, 32'sh1234_5678));
    pending_reqs.push_back(make_req(KIND_POP, 32'shFFFF_FFFF));
    pending_reqs.push_back(make_req(KIND_POP, 32'sh0000_0000));
    pending_reqs.push_back(make_req(KIND_POP, $urandom));

    // Random part: stretches that lean toward pushes or toward pops so that
    // the queue keeps running into both its full and its empty state.
    seg_left   = 0;
    push_heavy = 1'b0;
    push_pct   = 50;
    for (i = 0; i < N_RANDOM; i++) begin
      if (seg_left == 0) begin
        seg_left   = $urandom_range(10, 60);
        push_heavy = ~push_heavy;
        push_pct   = push_heavy ? $urandom_range(60, 85) : $urandom_range(15, 40);
      end
      seg_left--;
      if ($urandom_range(0, 99) < push_pct)
        pending_reqs.push_back(make_req(KIND_PUSH, draw_value()));
      else
        pending_reqs.push_back(make_req(KIND_POP, $urandom));
    end

    // Synchronous reset, released at a clock edge.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last request to be taken, then for its result.
    while (pending_reqs.size() > 0 || in_valid)
      @(posedge clk);
    while (expected_results.size() > 0)
      @(posedge clk);
    // Then keep clocking to catch any result that should not exist.
    repeat (8) @(posedge clk);

    $display("Covered %0d requests and %0d results: %0d pushes stored, %0d refused as full.",
             n_accepted, n_results, n_push_ok, n_full_refuse);
    $display("Pops returning a value: %0d; pops on an empty queue: %0d; errors: %0d.",
             n_pop_ok, n_empty_pop, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sorted_priority_queue.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_dpath.sv
hw/rtl/sorted_priority_queue.sv
sim/tb_sorted_priority_queue.sv
